/* src/nbf_pkg.sv */
package nbf_pkg;

	localparam int TABLE_DEPTH = 100;
	localparam logic [8:0] KICK_SPEED = 9'd190;
	localparam logic [8:0] LOW_SPEED = 9'd130;
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] jitter;
	} in_t;

	typedef struct packed {
		logic [8:0] duty_out;
		logic [8:0] target_speed;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_CUBE,
		ST_QUO,
		ST_REM,
		ST_DONE,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_QUO,
		OP_REM
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] a;
		logic [11:0] b;
		logic [15:0] c;
	} unit_req_t;

	function automatic logic [6:0] lvl_max(input logic [2:0] level);
		unique case (level)
			3'd2:    lvl_max = 7'd53;
			3'd3:    lvl_max = 7'd79;
			3'd4:    lvl_max = 7'd99;
			default: lvl_max = 7'd26;
		endcase
	endfunction

	// Reciprocal of the sweep maximum scaled by 2^16 and rounded down.
	function automatic logic [11:0] lvl_recip(input logic [2:0] level);
		unique case (level)
			3'd2:    lvl_recip = 12'd1236;
			3'd3:    lvl_recip = 12'd829;
			3'd4:    lvl_recip = 12'd661;
			default: lvl_recip = 12'd2520;
		endcase
	endfunction

	function automatic logic [7:0] lvl_restart(input logic [2:0] level);
		unique case (level)
			3'd2:    lvl_restart = 8'd120;
			3'd3:    lvl_restart = 8'd70;
			3'd4:    lvl_restart = 8'd45;
			default: lvl_restart = 8'd160;
		endcase
	endfunction

	function automatic logic [7:0] lvl_thresh(input logic [2:0] level);
		unique case (level)
			3'd2:    lvl_thresh = 8'd123;
			3'd3:    lvl_thresh = 8'd86;
			3'd4:    lvl_thresh = 8'd55;
			default: lvl_thresh = 8'd165;
		endcase
	endfunction

	function automatic logic [7:0] speed_rom(input logic [6:0] idx);
		logic [7:0] tbl [0:TABLE_DEPTH-1];
		tbl = '{
			8'd45, 8'd55, 8'd65, 8'd67, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
			8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
			8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90, 8'd91, 8'd97, 8'd98, 8'd99,
			8'd101, 8'd102, 8'd103, 8'd105, 8'd106, 8'd107, 8'd109, 8'd110, 8'd111, 8'd113,
			8'd114, 8'd115, 8'd117, 8'd118, 8'd119, 8'd121, 8'd122, 8'd123, 8'd125, 8'd126,
			8'd127, 8'd129, 8'd130, 8'd131, 8'd132, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139,
			8'd140, 8'd142, 8'd143, 8'd144, 8'd146, 8'd147, 8'd148, 8'd150, 8'd151, 8'd153,
			8'd155, 8'd158, 8'd160, 8'd163, 8'd165, 8'd168, 8'd170, 8'd171, 8'd172, 8'd173,
			8'd174, 8'd175, 8'd176, 8'd177, 8'd178, 8'd179, 8'd180, 8'd181, 8'd182, 8'd183,
			8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd195, 8'd200, 8'd210, 8'd220
		};
		if (idx < 7'(TABLE_DEPTH)) begin
			speed_rom = tbl[idx];
		end else begin
			speed_rom = 8'd0;
		end
	endfunction

endpackage

/* src/natural_breeze_fan_speed_generator.sv */
// Natural breeze fan speed generator.
// Items arrive on the item channel (valid/ready) and each gives exactly one
// beat on the result channel (valid/ready). The user must write the level
// through cfg_we and cfg_data only while the block is idle; the block
// itself does not enforce this. The level takes effect on the next item.
// A ramp tick, or an update event while the fan is stopped, goes from the
// idle step straight to the output step. An update event while the fan
// runs squares and cubes the sweep index on a shared multiplier, one
// product a cycle, then reduces the cube modulo the sweep maximum with a
// reciprocal product and a multiply-subtract through the same unit.
// Item ready is high only while the sequencer is idle.
// The result is held in an output register: the next item is accepted while
// a result still waits, and the sequencer holds its last step until the
// receiver frees the register.
// Reset clears all fan state, sets the level to one and leaves the channel
// empty.
module natural_breeze_fan_speed_generator (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  nbf_pkg::in_t   item,
	output logic           result_valid,
	input  logic           result_ready,
	output nbf_pkg::out_t  result,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_data
);
	import nbf_pkg::*;

	state_t      state_q, state_d;
	logic [2:0]  wind_level_q;
	logic [6:0]  sweep_index_q;
	logic        sweep_rising_q;
	logic        fan_running_q;
	logic [8:0]  target_q;
	logic [8:0]  ramp_q;
	logic        ramp_rising_q;
	logic        skip_q;
	logic [7:0]  jitter_q;
	logic [15:0] prod_q;
	logic [11:0] quo_q;
	logic [6:0]  rem_q;
	logic [8:0]  res_duty_q;
	logic [8:0]  res_target_q;
	logic        result_valid_q;
	out_t        result_q;

	unit_req_t   req;
	logic [15:0] unit_res;
	logic        accept;
	logic        load_out;
	logic [6:0]  max_c;
	logic [7:0]  rem_raw;
	logic [6:0]  rem_fix;
	logic [6:0]  idx_next;
	logic        rising_next;
	logic        ramp_up;
	logic [8:0]  ramp_next;
	logic [8:0]  kick;
	logic [6:0]  rom_idx;
	logic [8:0]  rom_val;
	logic [8:0]  done_target;
	logic        done_skip;

	nbf_unit u_unit (
		.req (req),
		.res (unit_res)
	);

	assign accept   = item_valid && item_ready;
	assign load_out = (state_q == ST_OUT) && (!result_valid_q || result_ready);
	assign max_c    = lvl_max(wind_level_q);
	assign kick     = 9'(KICK_SPEED + {1'b0, item.jitter});
	assign rom_idx  = 7'(TABLE_DEPTH) - rem_q;
	assign rom_val  = {1'b0, speed_rom(rom_idx)};
	assign rem_raw  = unit_res[7:0];
	assign rem_fix  = (rem_raw >= {1'b0, max_c}) ? 7'(rem_raw - {1'b0, max_c}) : rem_raw[6:0];

	always_comb begin
		req.op = OP_MUL;
		req.a  = prod_q;
		req.b  = {5'd0, sweep_index_q};
		req.c  = prod_q;
		unique case (state_q)
			ST_SQ: req.a = {9'd0, sweep_index_q};
			ST_QUO: begin
				req.op = OP_QUO;
				req.b  = lvl_recip(wind_level_q);
			end
			ST_REM: begin
				req.op = OP_REM;
				req.a  = {4'd0, quo_q};
				req.b  = {5'd0, max_c};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		idx_next    = sweep_index_q;
		rising_next = sweep_rising_q;
		if (sweep_rising_q) begin
			if (sweep_index_q < max_c) begin
				idx_next = 7'(sweep_index_q + 7'd1);
			end else begin
				rising_next = 1'b0;
			end
		end else begin
			if (sweep_index_q != 7'd0) begin
				idx_next = 7'(sweep_index_q - 7'd1);
			end else begin
				rising_next = 1'b1;
			end
		end
	end

	always_comb begin
		ramp_up = ramp_rising_q;
		if (ramp_q < target_q) begin
			ramp_up = 1'b1;
		end else if (ramp_q > target_q) begin
			ramp_up = 1'b0;
		end
		ramp_next = ramp_q;
		if (ramp_up) begin
			if (ramp_q <= target_q) begin
				ramp_next = 9'(ramp_q + 9'd3);
			end
		end else if (ramp_q > target_q) begin
			ramp_next = 9'(ramp_q - 9'd1);
		end
	end

	always_comb begin
		done_target = rom_val;
		done_skip   = 1'b0;
		if (rom_val < LOW_SPEED) begin
			if (!skip_q) begin
				done_skip = 1'b1;
			end else begin
				done_target = 9'(KICK_SPEED + {1'b0, jitter_q});
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (accept) begin
					if (item.cmd == CMD_UPDATE && fan_running_q) begin
						state_d = ST_SQ;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SQ:   state_d = ST_CUBE;
			ST_CUBE: state_d = ST_QUO;
			ST_QUO:  state_d = ST_REM;
			ST_REM:  state_d = ST_DONE;
			ST_DONE: state_d = ST_OUT;
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_level_q   <= 3'd1;
			sweep_index_q  <= '0;
			sweep_rising_q <= 1'b0;
			fan_running_q  <= 1'b0;
			target_q       <= '0;
			ramp_q         <= '0;
			ramp_rising_q  <= 1'b0;
			skip_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wind_level_q <= cfg_data;
			end
			if (accept) begin
				if (item.cmd == CMD_TICK) begin
					ramp_rising_q <= ramp_up;
					ramp_q        <= ramp_next;
				end else if (!fan_running_q) begin
					ramp_q        <= target_q;
					target_q      <= kick;
					fan_running_q <= 1'b1;
				end else begin
					ramp_q         <= target_q;
					sweep_index_q  <= idx_next;
					sweep_rising_q <= rising_next;
				end
			end
			if (state_q == ST_DONE) begin
				if (rem_q == 7'd0) begin
					target_q <= {1'b0, lvl_restart(wind_level_q)};
				end else begin
					target_q      <= done_target;
					skip_q        <= done_skip;
					fan_running_q <= rom_val >= {1'b0, lvl_thresh(wind_level_q)};
				end
			end
			if (load_out) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jitter_q <= item.jitter;
			if (item.cmd == CMD_TICK) begin
				res_duty_q   <= ramp_q;
				res_target_q <= target_q;
			end else begin
				res_duty_q   <= target_q;
				res_target_q <= kick;
			end
		end
		unique case (state_q)
			ST_SQ, ST_CUBE: prod_q <= unit_res;
			ST_QUO:         quo_q  <= unit_res[11:0];
			ST_REM:         rem_q  <= rem_fix;
			ST_DONE: begin
				if (rem_q == 7'd0) begin
					res_target_q <= {1'b0, lvl_restart(wind_level_q)};
				end else begin
					res_target_q <= done_target;
				end
			end
			default: begin
			end
		endcase
		if (load_out) begin
			result_q.duty_out     <= res_duty_q;
			result_q.target_speed <= res_target_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* src/nbf_unit.sv */
module nbf_unit (
	input  nbf_pkg::unit_req_t req,
	output logic [15:0]        res
);
	import nbf_pkg::*;

	logic [27:0] prod;

	assign prod = req.a * req.b;

	always_comb begin
		unique case (req.op)
			OP_MUL:  res = prod[15:0];
			OP_QUO:  res = {4'd0, prod[27:16]};
			OP_REM:  res = 16'(req.c - prod[15:0]);
			default: res = prod[15:0];
		endcase
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import nbf_pkg::*;

	localparam int QUIET_LIMIT = 600;
	localparam int PHASES = 10;
	localparam int PHASE_BEATS = 128;
	localparam int PHASE_LEVELS [PHASES] = '{4, 1, 0, 5, 7, 2, 3, 6, 4, 1};
	localparam int PHASE_UPDATE_PCT [PHASES] = '{85, 50, 30, 60, 20, 50, 70, 40, 50, 25};

	localparam logic [7:0] BREEZE_SPEEDS [0:99] = '{
		8'd45, 8'd55, 8'd65, 8'd67, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
		8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
		8'd85, 8'd86, 8'd87, 8'd88, 8'd89, 8'd90, 8'd91, 8'd97, 8'd98, 8'd99,
		8'd101, 8'd102, 8'd103, 8'd105, 8'd106, 8'd107, 8'd109, 8'd110, 8'd111, 8'd113,
		8'd114, 8'd115, 8'd117, 8'd118, 8'd119, 8'd121, 8'd122, 8'd123, 8'd125, 8'd126,
		8'd127, 8'd129, 8'd130, 8'd131, 8'd132, 8'd134, 8'd135, 8'd136, 8'd138, 8'd139,
		8'd140, 8'd142, 8'd143, 8'd144, 8'd146, 8'd147, 8'd148, 8'd150, 8'd151, 8'd153,
		8'd155, 8'd158, 8'd160, 8'd163, 8'd165, 8'd168, 8'd170, 8'd171, 8'd172, 8'd173,
		8'd174, 8'd175, 8'd176, 8'd177, 8'd178, 8'd179, 8'd180, 8'd181, 8'd182, 8'd183,
		8'd184, 8'd185, 8'd186, 8'd187, 8'd188, 8'd189, 8'd195, 8'd200, 8'd210, 8'd220
	};

	class breeze_tracker;
		logic [2:0] level;
		logic [6:0] sweep;
		bit sweep_up;
		bit spinning;
		bit ramp_up;
		bit skip_low;
		logic [8:0] target;
		logic [8:0] ramp;
		out_t speed_queue [$];
		int errors;

		function new();
			level = 3'd1;
			sweep = '0;
			sweep_up = 1'b0;
			spinning = 1'b0;
			ramp_up = 1'b0;
			skip_low = 1'b0;
			target = '0;
			ramp = '0;
			errors = 0;
		endfunction

		function int pending();
			return speed_queue.size();
		endfunction

		task report_mismatch(string what);
			if (errors < 200) begin
				$display("%0t ns: %s", $time, what);
			end
			errors++;
		endtask

		function void pattern_step(logic [7:0] jitter);
			int unsigned top;
			int unsigned restart;
			int unsigned idx;
			int unsigned cube;
			int unsigned rem;
			ramp = target;
			if (!spinning) begin
				target = KICK_SPEED + 9'(jitter);
				spinning = 1'b1;
				return;
			end
			case (level)
				3'd2: begin
					top = 53;
					restart = 120;
				end
				3'd3: begin
					top = 79;
					restart = 70;
				end
				3'd4: begin
					top = 99;
					restart = 45;
				end
				default: begin
					top = 26;
					restart = 160;
				end
			endcase
			if (sweep_up) begin
				if (sweep < top) begin
					sweep = sweep + 7'd1;
				end else begin
					sweep_up = 1'b0;
				end
			end else begin
				if (sweep > 0) begin
					sweep = sweep - 7'd1;
				end else begin
					sweep_up = 1'b1;
				end
			end
			idx = sweep;
			cube = (idx * idx) & 32'hFFFF;
			cube = (cube * idx) & 32'hFFFF;
			rem = cube % top;
			if (rem == 0) begin
				target = 9'(restart);
				return;
			end
			target = 9'(BREEZE_SPEEDS[TABLE_DEPTH - rem]);
			spinning = (target >= BREEZE_SPEEDS[TABLE_DEPTH - top]);
			if (target < LOW_SPEED) begin
				if (!skip_low) begin
					skip_low = 1'b1;
				end else begin
					skip_low = 1'b0;
					target = KICK_SPEED + 9'(jitter);
				end
			end else begin
				skip_low = 1'b0;
			end
		endfunction

		function void ramp_step();
			if (ramp < target) begin
				ramp_up = 1'b1;
			end else if (ramp > target) begin
				ramp_up = 1'b0;
			end
			if (ramp_up) begin
				if (ramp <= target) begin
					ramp = ramp + 9'd3;
				end
			end else if (ramp > target) begin
				ramp = ramp - 9'd1;
			end
		endfunction

		function void take_item(in_t beat);
			out_t want;
			if (beat.cmd == CMD_UPDATE) begin
				pattern_step(beat.jitter);
				want.duty_out = ramp;
			end else begin
				want.duty_out = ramp;
				ramp_step();
			end
			want.target_speed = target;
			speed_queue.push_back(want);
		endfunction

		task match_result(out_t got);
			out_t want;
			if (speed_queue.size() == 0) begin
				report_mismatch($sformatf("unexpected result beat: duty %0d target %0d",
					got.duty_out, got.target_speed));
				return;
			end
			want = speed_queue.pop_front();
			if (got.duty_out !== want.duty_out) begin
				report_mismatch($sformatf("duty_out is %0d, predicted %0d",
					got.duty_out, want.duty_out));
			end
			if (got.target_speed !== want.target_speed) begin
				report_mismatch($sformatf("target_speed is %0d, predicted %0d",
					got.target_speed, want.target_speed));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_t item;
	logic result_valid;
	logic result_ready;
	out_t result;
	logic cfg_we;
	logic [2:0] cfg_data;
	breeze_tracker tracker;

	natural_breeze_fan_speed_generator uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_beat(logic cmd, logic [7:0] jitter);
		in_t beat;
		beat.cmd = cmd;
		beat.jitter = jitter;
		@(negedge clk);
		item_valid <= 1'b1;
		item <= beat;
		@(posedge clk);
		while (!item_ready) begin
			@(posedge clk);
		end
		tracker.take_item(beat);
	endtask

	task automatic hold_off(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			item_valid <= 1'b0;
			item <= in_t'(9'($urandom));
		end
	endtask

	task automatic drain();
		hold_off(1);
		while (tracker.pending() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic set_level(logic [2:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		tracker.level = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_run(int beats, int update_pct);
		int burst;
		bit steady;
		logic cmd;
		steady = ($urandom_range(0, 3) == 0);
		burst = $urandom_range(1, 20);
		for (int n = 0; n < beats; n++) begin
			if (n == beats / 2) begin
				drain();
			end
			cmd = ($urandom_range(1, 100) <= update_pct) ? CMD_UPDATE : CMD_TICK;
			send_beat(cmd, 8'($urandom_range(0, 255)));
			burst--;
			if (burst == 0) begin
				if (!steady) begin
					hold_off($urandom_range(1, 12));
				end
				burst = $urandom_range(1, 20);
			end
		end
	endtask

	// The receiver stalls on a 32-bit ready pattern that is redrawn each time it runs out.
	initial begin : receiver
		logic [31:0] pattern;
		int step;
		result_ready <= 1'b0;
		pattern = '1;
		step = 0;
		forever begin
			@(negedge clk);
			if (step == 0) begin
				case ($urandom_range(0, 3))
					0: pattern = '1;
					1: pattern = $urandom;
					2: pattern = $urandom | $urandom;
					default: pattern = $urandom & $urandom;
				endcase
			end
			result_ready <= pattern[step];
			step = (step + 1) % 32;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			tracker.match_result(result);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Mismatches found");
		$finish;
	end

	initial begin : stimulus
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_data <= 3'd1;
		arst_n <= 1'b0;
		tracker = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// The first update gives the kick and the next finds the sweep at zero, so the restart speed follows the kick.
		send_beat(CMD_TICK, 8'h00);
		send_beat(CMD_TICK, 8'hFF);
		send_beat(CMD_UPDATE, 8'h00);
		repeat (3) send_beat(CMD_TICK, 8'($urandom_range(0, 255)));
		send_beat(CMD_UPDATE, 8'hFF);
		send_beat(CMD_UPDATE, 8'h55);
		send_beat(CMD_UPDATE, 8'hAA);
		repeat (2) send_beat(CMD_TICK, 8'h00);
		for (int n = 0; n < 6; n++) begin
			send_beat(CMD_UPDATE, (n % 2 == 0) ? 8'h00 : 8'hFF);
		end
		repeat (4) send_beat(CMD_TICK, 8'hFF);

		for (int p = 0; p < PHASES; p++) begin
			set_level(3'(PHASE_LEVELS[p]));
			random_run(PHASE_BEATS, PHASE_UPDATE_PCT[p]);
		end

		drain();
		repeat (30) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
